// File: rtl/core/det_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// det_pkg
// Shared types and constants for the date-sorted event table.
// ----------------------------------------------------------------------------
package det_pkg;

  localparam int ACTION_W    = 2;
  localparam int ID_W        = 32;
  localparam int DATE_W      = 32;
  localparam int QUEUE_DEPTH = 2;
  // Width of the entry count field on the response channel
  localparam int ENTRY_CNT_W = 6;

  // Action codes as they arrive on the request channel
  localparam logic [ACTION_W-1:0] ACT_INSERT    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_HAS_ID    = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_GET_DATE  = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_HAS_DATE  = 2'd3;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_HAS_ID,
    OP_GET_DATE,
    OP_HAS_DATE
  } op_t;

  typedef struct packed {
    op_t                     op;
    logic signed [ID_W-1:0]  id;
    logic [DATE_W-1:0]       date;
  } cmd_t;

  typedef struct packed {
    logic signed [ID_W-1:0]  id;
    logic [DATE_W-1:0]       date;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_INS_CMP,
    ST_INS_LAST,
    ST_ID_CMP,
    ST_BS_RD,
    ST_BS_CMP,
    ST_RESP
  } state_t;

  function automatic op_t decode_action(input logic [ACTION_W-1:0] action);
    op_t op;
    case (action)
      ACT_INSERT:   op = OP_INSERT;
      ACT_HAS_ID:   op = OP_HAS_ID;
      ACT_GET_DATE: op = OP_GET_DATE;
      ACT_HAS_DATE: op = OP_HAS_DATE;
      default:      op = OP_HAS_DATE;
    endcase
    return op;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/det_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// det_in_if
// Request channel: action, event id and event date with valid/ready.
// ----------------------------------------------------------------------------
interface det_in_if import det_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [ACTION_W-1:0]     action;
  logic signed [ID_W-1:0]  event_id;
  logic [DATE_W-1:0]       event_date;

  modport source (output valid, action, event_id, event_date, input ready);
  modport sink   (input valid, action, event_id, event_date, output ready);
endinterface
`default_nettype wire

// File: rtl/core/det_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// det_out_if
// Response channel: one result per request with valid/ready.
// ----------------------------------------------------------------------------
interface det_out_if import det_pkg::*; #(parameter int CNT_W = ENTRY_CNT_W) ();
  logic              valid;
  logic              ready;
  logic              accepted;
  logic              found;
  logic [DATE_W-1:0] found_date;
  logic [CNT_W-1:0]  entry_count;

  modport source (output valid, accepted, found, found_date, entry_count, input ready);
  modport sink   (input valid, accepted, found, found_date, entry_count, output ready);
endinterface
`default_nettype wire

// File: rtl/core/det_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// det_front
// Request stage: registers each transfer and decodes the action into a command.
// ----------------------------------------------------------------------------
module det_front import det_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  det_in_if.sink    req,
  output logic      push_valid,
  output cmd_t      push_cmd,
  input  wire logic push_ready
);

  logic hold_valid;
  cmd_t hold_cmd;
  logic take;

  assign req.ready  = !hold_valid || push_ready;
  assign take       = req.valid && req.ready;
  assign push_valid = hold_valid;
  assign push_cmd   = hold_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (take) begin
      hold_valid <= 1'b1;
    end else if (push_ready) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hold_cmd.op   <= decode_action(req.action);
      hold_cmd.id   <= req.event_id;
      hold_cmd.date <= req.event_date;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/det_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// det_queue
// Short command FIFO between the request stage and the table engine.
// ----------------------------------------------------------------------------
module det_queue import det_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push_valid,
  input  cmd_t      push_cmd,
  output logic      push_ready,
  output logic      pop_valid,
  output cmd_t      pop_cmd,
  input  wire logic pop_ready
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [LVL_W-1:0] level;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (level != LVL_W'(QUEUE_DEPTH));
  assign pop_valid  = (level != '0);
  assign pop_cmd    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        level <= level + 1'b1;
      end else if (do_pop && !do_push) begin
        level <= level - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/det_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// det_back
// Table engine: sorted entry memory, insert walk, id scan, binary date search
// and the response register.
// ----------------------------------------------------------------------------
module det_back import det_pkg::*; #(
  parameter int CAPACITY = 32,
  parameter int CNT_W    = 6,
  parameter int IDX_W    = 5
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  input  cmd_t      cmd_in,
  output logic      cmd_pop,
  det_out_if.source rsp
);

  entry_t           mem [CAPACITY];
  entry_t           mem_q;

  state_t           state;
  state_t           state_next;
  cmd_t             cmd;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_m1;
  logic [IDX_W-1:0] idx;
  logic [CNT_W-1:0] lo;
  logic [CNT_W-1:0] hi;
  logic [CNT_W-1:0] mid;
  logic [CNT_W-1:0] mid_q;
  logic [CNT_W-1:0] lo_next;
  logic [CNT_W-1:0] hi_next;

  logic             res_acc;
  logic             res_found;
  logic [DATE_W-1:0] res_date;

  logic             rsp_valid;
  logic             rsp_acc;
  logic             rsp_found;
  logic [DATE_W-1:0] rsp_date;
  logic [ENTRY_CNT_W-1:0] rsp_cnt;

  logic             full;
  logic             out_free;
  logic             ins_ge;
  logic             id_hit;
  logic             id_last;
  logic             bs_hit;

  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;
  logic             cnt_inc;
  entry_t           new_entry;

  assign full      = (cnt == CNT_W'(CAPACITY));
  assign cnt_m1    = cnt - 1'b1;
  assign out_free  = !rsp_valid || rsp.ready;
  assign ins_ge    = (mem_q.date >= cmd.date);
  assign id_hit    = (mem_q.id == cmd.id);
  assign id_last   = (CNT_W'(idx) == cnt_m1);
  assign bs_hit    = (mem_q.date == cmd.date);
  assign mid       = lo + ((hi - lo) >> 1);
  assign new_entry = '{id: cmd.id, date: cmd.date};

  always_comb begin
    lo_next = lo;
    hi_next = hi;
    if (mem_q.date < cmd.date) begin
      lo_next = mid_q + 1'b1;
    end else begin
      hi_next = mid_q;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd_valid) state_next = ST_START;
      end
      ST_START: begin
        case (cmd.op)
          OP_INSERT: begin
            state_next = (full || cnt == '0) ? ST_RESP : ST_INS_CMP;
          end
          OP_HAS_ID, OP_GET_DATE: begin
            state_next = (cnt == '0) ? ST_RESP : ST_ID_CMP;
          end
          default: begin
            state_next = (cnt == '0) ? ST_RESP : ST_BS_RD;
          end
        endcase
      end
      ST_INS_CMP: begin
        if (!ins_ge) begin
          state_next = ST_RESP;
        end else if (idx == '0) begin
          state_next = ST_INS_LAST;
        end
      end
      ST_INS_LAST: state_next = ST_RESP;
      ST_ID_CMP: begin
        if (id_hit || id_last) state_next = ST_RESP;
      end
      ST_BS_RD: state_next = ST_BS_CMP;
      ST_BS_CMP: begin
        if (bs_hit || lo_next >= hi_next) begin
          state_next = ST_RESP;
        end else begin
          state_next = ST_BS_RD;
        end
      end
      ST_RESP: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Memory port and control outputs
  always_comb begin
    cmd_pop = 1'b0;
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = new_entry;
    cnt_inc = 1'b0;
    case (state)
      ST_IDLE: cmd_pop = cmd_valid;
      ST_START: begin
        case (cmd.op)
          OP_INSERT: begin
            if (!full && cnt == '0) begin
              wr_en   = 1'b1;
              cnt_inc = 1'b1;
            end else if (!full) begin
              rd_en   = 1'b1;
              rd_addr = cnt_m1[IDX_W-1:0];
            end
          end
          OP_HAS_ID, OP_GET_DATE: begin
            rd_en = (cnt != '0);
          end
          default: ;
        endcase
      end
      ST_INS_CMP: begin
        // Walk down from the top: shift entries at or after the new date up one
        wr_en   = 1'b1;
        wr_addr = idx + 1'b1;
        if (ins_ge) begin
          wr_data = mem_q;
          if (idx != '0) begin
            rd_en   = 1'b1;
            rd_addr = idx - 1'b1;
          end
        end else begin
          cnt_inc = 1'b1;
        end
      end
      ST_INS_LAST: begin
        wr_en   = 1'b1;
        cnt_inc = 1'b1;
      end
      ST_ID_CMP: begin
        if (!id_hit && !id_last) begin
          rd_en   = 1'b1;
          rd_addr = idx + 1'b1;
        end
      end
      ST_BS_RD: begin
        rd_en   = 1'b1;
        rd_addr = mid[IDX_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cnt_inc) begin
        cnt <= cnt + 1'b1;
      end
      if (state == ST_RESP && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cnt_inc) begin
      res_acc <= 1'b1;
    end
    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd       <= cmd_in;
          res_acc   <= 1'b0;
          res_found <= 1'b0;
          res_date  <= '0;
        end
      end
      ST_START: begin
        idx <= (cmd.op == OP_INSERT) ? cnt_m1[IDX_W-1:0] : '0;
        lo  <= '0;
        hi  <= cnt;
      end
      ST_INS_CMP: begin
        if (ins_ge && idx != '0) begin
          idx <= idx - 1'b1;
        end
      end
      ST_ID_CMP: begin
        if (id_hit) begin
          res_found <= 1'b1;
          if (cmd.op == OP_GET_DATE) begin
            res_date <= mem_q.date;
          end
        end else begin
          idx <= idx + 1'b1;
        end
      end
      ST_BS_RD: mid_q <= mid;
      ST_BS_CMP: begin
        if (bs_hit) begin
          res_found <= 1'b1;
        end
        lo <= lo_next;
        hi <= hi_next;
      end
      ST_RESP: begin
        if (out_free) begin
          rsp_acc   <= res_acc;
          rsp_found <= res_found;
          rsp_date  <= res_date;
          rsp_cnt   <= ENTRY_CNT_W'(cnt);
        end
      end
      default: ;
    endcase
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.accepted    = rsp_acc;
  assign rsp.found       = rsp_found;
  assign rsp.found_date  = rsp_date;
  assign rsp.entry_count = rsp_cnt;

endmodule
`default_nettype wire

// File: rtl/core/date_sorted_event_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// date_sorted_event_table
// Fixed-capacity event table kept in ascending date order, with insert,
// id lookup and binary date search.
// ----------------------------------------------------------------------------
// Every request gives exactly one response. Requests are registered and
// decoded, then wait in a two-entry queue for the table engine, which owns a
// single-port-read, single-port-write entry memory and runs one command at a
// time. An insert walks from the top entry down, shifting each later entry
// up one place; an id query scans linearly from entry 0; a date query runs a
// binary search in which each step first reads memory and then compares,
// because memory reads are registered. Requests keep being accepted while
// the engine works, until the queue fills. The memory needs no clearing
// after reset; only entries below the stored count are ever read.
module date_sorted_event_table import det_pkg::*; #(
  parameter int CAPACITY = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  det_in_if.sink    req,
  det_out_if.source rsp
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic push_valid;
  cmd_t push_cmd;
  logic push_ready;
  logic pop_valid;
  cmd_t pop_cmd;
  logic pop_ready;

  det_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready)
  );

  det_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_cmd    (pop_cmd),
    .pop_ready  (pop_ready)
  );

  det_back #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W),
    .IDX_W    (IDX_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (pop_valid),
    .cmd_in    (pop_cmd),
    .cmd_pop   (pop_ready),
    .rsp       (rsp)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.entry_count <= CNT_W'(CAPACITY)))
    else $error("entry count above capacity");

  a_acc_vs_found: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.accepted && rsp.found))
    else $error("insert reported as found");

  a_date_needs_found: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.found_date != '0) |-> rsp.found)
    else $error("date returned without a hit");

  a_acc_nonempty: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.accepted) |-> (rsp.entry_count != '0))
    else $error("accepted insert left table empty");

endmodule
`default_nettype wire
